@@ sv/efi_pkg.sv @@
// ----------------------------------------------------------------------------
// efi_pkg
// shared types, codes and helpers of the euler force integrator
// ----------------------------------------------------------------------------
`default_nettype none

package efi_pkg;

    localparam int unsigned SUBSTEPS_DEF = 1;
    localparam logic [30:0] TIME_STEP_RST = 31'd1092;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_FORCE = 2'd1,
        OP_INTEG = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQ_RUN,
        ST_F_ENTRY,
        ST_F_MUL,
        ST_F_SCL,
        ST_F_PRE,
        ST_DIV,
        ST_F_QUO,
        ST_F_ADD,
        ST_I_DT,
        ST_I_VMUL,
        ST_I_VADD,
        ST_I_PMUL,
        ST_I_PADD,
        ST_OUT
    } state_t;

    // saturate a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/euler_force_integrator_top.sv @@
// ----------------------------------------------------------------------------
// euler_force_integrator_top
// explicit euler force integrator, signed q16.16, saturating
// ----------------------------------------------------------------------------
// channel   direction  handshake                  content
// s_axis    in         s_axis_tvalid/tready       begin, force or integrate request
// m_axis    out        m_axis_tvalid/tready       new velocity and position
// cfg       in         cfg_valid/cfg_ready        time step register
//
// begin: loads the entity. force: per axis an entry step, a multiply and scale
// when scaled by speed, and a 48-step bit-serial divider and a sign fix when
// divided by mass; before them the speed when needed, once after each begin or
// integrate (three squares on the shared multiplier and a 32-step square root).
// integrate: the sub-step (reciprocal multiply on the shared multiplier), then
// per sub-step and axis a velocity and a position multiply-add; output register.
// one request at a time; s_axis_tready is low while a request is in work.
// a finished result sits in the output register; a new request is accepted
// meanwhile and only the next integrate waits on it. reset is asynchronous.
`default_nettype none

module euler_force_integrator_top #(
    parameter int unsigned SUBSTEPS = efi_pkg::SUBSTEPS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // vec_x, vec_y, vec_z, body_mass, scale_by_speed, skip_mass, zero pad
    input  wire logic [135:0]  s_axis_tdata,
    // op
    input  wire logic [1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y, new_pos_z
    output logic [191:0]       m_axis_tdata,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [30:0]   cfg_data
);
    import efi_pkg::*;

    localparam int SW = $clog2(SUBSTEPS + 1);
    // sub-step by reciprocal: floor(ts / SUBSTEPS) = (ts * DT_RECIP) >> DT_SH
    localparam int DT_SH = 31 + $clog2(SUBSTEPS);
    localparam logic [63:0] DT_RECIP =
        ((64'd1 << DT_SH) + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS);

    state_t state_reg, state_next;
    logic signed [31:0] vel_reg [3], vel_next [3];
    logic signed [31:0] acc_reg [3], acc_next [3];
    logic signed [31:0] pos_reg [3], pos_next [3];
    logic signed [31:0] f_reg   [3], f_next   [3];
    logic [30:0] mass_reg, mass_next;
    logic [31:0] speed_reg, speed_next;
    logic        known_reg, known_next;
    logic [30:0] ts_reg, ts_next;
    logic [30:0] dt_reg, dt_next;
    logic        scale_reg, scale_next;
    logic        skip_reg, skip_next;
    logic [1:0]  idx_reg, idx_next;
    logic [SW-1:0] step_reg, step_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic signed [31:0] fcur_reg, fcur_next;
    logic        neg_reg, neg_next;
    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg, prod_next;
    // bit-serial square root
    logic [63:0] sq_sum_reg, sq_sum_next;
    logic [32:0] sq_rem_reg, sq_rem_next;
    logic [31:0] sq_root_reg, sq_root_next;
    logic [34:0] sq_remt, sq_trial;
    // bit-serial restoring divider, quotient shifts into the dividend
    logic [47:0] dv_dd_reg, dv_dd_next;
    logic [31:0] dv_rem_reg, dv_rem_next;
    logic [30:0] dv_den_reg, dv_den_next;
    logic [31:0] dv_remt;
    logic        out_valid_reg, out_valid_next;
    logic [191:0] out_reg, out_next;

    logic signed [31:0] mulq;
    logic [31:0] fmag;
    logic signed [48:0] quo;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign prod_next = mul_a * mul_b;
    assign mulq      = sat66(prod_reg >>> 16);
    assign sq_remt   = {sq_rem_reg, sq_sum_reg[63:62]};
    assign sq_trial  = {1'b0, sq_root_reg, 2'b01};
    assign dv_remt   = {dv_rem_reg[30:0], dv_dd_reg[47]};
    assign fmag      = fcur_reg[31] ? 32'(-{1'b0, fcur_reg}) : 32'(fcur_reg);
    assign quo       = neg_reg ? -$signed({1'b0, dv_dd_reg}) : $signed({1'b0, dv_dd_reg});

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_MUL:
            begin
                mul_a = 33'(vel_reg[idx_reg]);
                mul_b = 33'(vel_reg[idx_reg]);
            end
            ST_F_MUL:
            begin
                mul_a = 33'(f_reg[idx_reg]);
                mul_b = $signed({1'b0, speed_reg});
            end
            ST_I_DT:
            begin
                mul_a = $signed({2'b0, ts_reg});
                mul_b = $signed({1'b0, DT_RECIP[31:0]});
            end
            ST_I_VMUL:
            begin
                mul_a = 33'(acc_reg[idx_reg]);
                mul_b = $signed({2'b0, dt_reg});
            end
            ST_I_PMUL:
            begin
                mul_a = 33'(vel_reg[idx_reg]);
                mul_b = $signed({2'b0, dt_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        vel_next     = vel_reg;
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        f_next       = f_reg;
        mass_next    = mass_reg;
        speed_next   = speed_reg;
        known_next   = known_reg;
        ts_next      = ts_reg;
        dt_next      = dt_reg;
        scale_next   = scale_reg;
        skip_next    = skip_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        fcur_next    = fcur_reg;
        neg_next     = neg_reg;
        sq_sum_next  = sq_sum_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        dv_dd_next   = dv_dd_reg;
        dv_rem_next  = dv_rem_reg;
        dv_den_next  = dv_den_reg;
        out_next     = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (cfg_valid)
            ts_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    f_next[0]  = s_axis_tdata[31:0];
                    f_next[1]  = s_axis_tdata[63:32];
                    f_next[2]  = s_axis_tdata[95:64];
                    scale_next = s_axis_tdata[127];
                    skip_next  = s_axis_tdata[128];
                    idx_next   = '0;
                    case (op_t'(s_axis_tuser))
                        OP_BEGIN:
                        begin
                            vel_next[0] = s_axis_tdata[31:0];
                            vel_next[1] = s_axis_tdata[63:32];
                            vel_next[2] = s_axis_tdata[95:64];
                            acc_next[0] = '0;
                            acc_next[1] = '0;
                            acc_next[2] = '0;
                            mass_next   = s_axis_tdata[126:96];
                            known_next  = 1'b0;
                        end
                        OP_FORCE:
                        begin
                            sq_sum_next = '0;
                            if (s_axis_tdata[127] && !known_reg)
                                state_next = ST_SQ_MUL;
                            else
                                state_next = ST_F_ENTRY;
                        end
                        OP_INTEG:
                        begin
                            pos_next[0] = s_axis_tdata[31:0];
                            pos_next[1] = s_axis_tdata[63:32];
                            pos_next[2] = s_axis_tdata[95:64];
                            cnt_next    = 6'd48;
                            state_next  = ST_I_DT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            // sum of squares over the three axes
            ST_SQ_MUL:
            begin
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                sq_sum_next = sq_sum_reg + prod_reg[63:0];
                if (idx_reg == 2'd2)
                begin
                    idx_next     = '0;
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = '0;
                    state_next   = ST_SQ_RUN;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            // one root bit per cycle
            ST_SQ_RUN:
            begin
                sq_sum_next = {sq_sum_reg[61:0], 2'b00};
                if (sq_remt >= sq_trial)
                begin
                    sq_rem_next  = 33'(sq_remt - sq_trial);
                    sq_root_next = {sq_root_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_next  = sq_remt[32:0];
                    sq_root_next = {sq_root_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    speed_next = (sq_remt >= sq_trial) ? {sq_root_reg[30:0], 1'b1}
                                                       : {sq_root_reg[30:0], 1'b0};
                    known_next = 1'b1;
                    state_next = ST_F_ENTRY;
                end
            end
            ST_F_ENTRY:
            begin
                fcur_next  = f_reg[idx_reg];
                state_next = scale_reg ? ST_F_MUL : ST_F_PRE;
            end
            ST_F_MUL:
            begin
                state_next = ST_F_SCL;
            end
            ST_F_SCL:
            begin
                fcur_next  = mulq;
                state_next = ST_F_PRE;
            end
            ST_F_PRE:
            begin
                if (!skip_reg && mass_reg != '0)
                begin
                    neg_next    = fcur_reg[31];
                    dv_dd_next  = {fmag, 16'b0};
                    dv_rem_next = '0;
                    dv_den_next = mass_reg;
                    cnt_next    = '0;
                    state_next  = ST_DIV;
                end
                else
                begin
                    state_next = ST_F_ADD;
                end
            end
            // one quotient bit per cycle
            ST_DIV:
            begin
                if (dv_remt >= {1'b0, dv_den_reg})
                begin
                    dv_rem_next = dv_remt - {1'b0, dv_den_reg};
                    dv_dd_next  = {dv_dd_reg[46:0], 1'b1};
                end
                else
                begin
                    dv_rem_next = dv_remt;
                    dv_dd_next  = {dv_dd_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                    state_next = ST_F_QUO;
            end
            ST_F_QUO:
            begin
                fcur_next  = sat66(66'(quo));
                state_next = ST_F_ADD;
            end
            ST_F_ADD:
            begin
                acc_next[idx_reg] = sat66(66'(acc_reg[idx_reg]) + 66'(fcur_reg));
                if (idx_reg == 2'd2)
                    state_next = ST_IDLE;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_F_ENTRY;
                end
            end
            // time step times the reciprocal of the sub-step count
            ST_I_DT:
            begin
                state_next = ST_I_VMUL;
            end
            ST_I_VMUL:
            begin
                if (cnt_reg == 6'd48)
                begin
                    dt_next   = prod_reg[DT_SH +: 31];
                    step_next = '0;
                    idx_next  = '0;
                    cnt_next  = '0;
                    state_next = ST_I_VMUL;
                end
                else
                    state_next = ST_I_VADD;
            end
            ST_I_VADD:
            begin
                vel_next[idx_reg] = sat66(66'(vel_reg[idx_reg]) + 66'(mulq));
                state_next = ST_I_PMUL;
            end
            ST_I_PMUL:
            begin
                state_next = ST_I_PADD;
            end
            ST_I_PADD:
            begin
                pos_next[idx_reg] = sat66(66'(pos_reg[idx_reg]) + 66'(mulq));
                if (idx_reg == 2'd2)
                begin
                    idx_next = '0;
                    if (step_reg == SW'(SUBSTEPS - 1))
                        state_next = ST_OUT;
                    else
                    begin
                        step_next  = step_reg + SW'(1);
                        state_next = ST_I_VMUL;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_I_VMUL;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next = {pos_reg[2], pos_reg[1], pos_reg[0],
                                vel_reg[2], vel_reg[1], vel_reg[0]};
                    out_valid_next = 1'b1;
                    known_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vel_reg       <= '{default: '0};
            acc_reg       <= '{default: '0};
            mass_reg      <= '0;
            speed_reg     <= '0;
            known_reg     <= 1'b0;
            ts_reg        <= TIME_STEP_RST;
            idx_reg       <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vel_reg       <= vel_next;
            acc_reg       <= acc_next;
            mass_reg      <= mass_next;
            speed_reg     <= speed_next;
            known_reg     <= known_next;
            ts_reg        <= ts_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        f_reg       <= f_next;
        dt_reg      <= dt_next;
        scale_reg   <= scale_next;
        skip_reg    <= skip_next;
        fcur_reg    <= fcur_next;
        neg_reg     <= neg_next;
        prod_reg    <= prod_next;
        sq_sum_reg  <= sq_sum_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        dv_dd_reg   <= dv_dd_next;
        dv_rem_reg  <= dv_rem_next;
        dv_den_reg  <= dv_den_next;
        out_reg     <= out_next;
    end

    // a result appears only from the output state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    // speed becomes known only at the end of the root iteration
    a_speed_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(known_reg) |-> $past(state_reg == ST_SQ_RUN && cnt_reg == 6'd31))
        else $error("speed marked known without root");

    // divider never runs past its last quotient bit
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= 6'd47)
        else $error("divider count overrun");

    // the summed acceleration moves only on a begin or a force add
    a_acc_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(acc_reg[0]) |-> $past(state_reg == ST_IDLE || state_reg == ST_F_ADD))
        else $error("acceleration changed unexpectedly");

endmodule

`default_nettype wire

@@ bench/tb_euler_force_integrator_top.sv @@
// ----------------------------------------------------------------------------
// tb_euler_force_integrator_top
// self-checking bench: begin, force and integrate requests against a predictor
// of the q16.16 euler integrator, with random stalls on both streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_euler_force_integrator_top;

    import efi_pkg::*;

    localparam int unsigned STEPS = SUBSTEPS_DEF;
    localparam int unsigned ITEM_COUNT = 1250;
    localparam int unsigned STALL_LIMIT = 20000;

    // one motion result: velocity then position
    typedef struct packed {
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
        logic signed [31:0] vz;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
    } motion_t;

    // predictor of the integrator and store of awaited motion results
    class motion_scoreboard;
        logic signed [31:0] vel [3];
        logic signed [31:0] accel [3];
        logic [31:0] mass;
        logic [31:0] speed;
        bit speed_valid;
        logic [30:0] step_size;
        motion_t awaited [$];
        int errors;
        int results_seen;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                vel[i] = 0;
                accel[i] = 0;
            end
            mass = 0;
            speed = 0;
            speed_valid = 0;
            step_size = TIME_STEP_RST;
            errors = 0;
            results_seen = 0;
        endfunction

        function logic signed [31:0] clamp(input logic signed [95:0] v);
            logic signed [31:0] r;
            if (v > 96'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -96'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        endfunction

        // signed times unsigned q16.16, floor shift
        function logic signed [31:0] scale(input logic signed [31:0] a, input logic [31:0] b);
            logic signed [95:0] p;
            p = 96'(a) * $signed({64'd0, b});
            return clamp(p >>> 16);
        endfunction

        function logic [31:0] root_of_squares();
            logic [65:0] s;
            logic [65:0] r;
            logic [65:0] t;
            s = 0;
            for (int i = 0; i < 3; i++)
                s += 66'($signed(64'(vel[i])) * $signed(64'(vel[i])));
            r = 0;
            for (int b = 32; b >= 0; b--)
            begin
                t = r | (66'd1 << b);
                if (t * t <= s)
                    r = t;
            end
            return r[31:0];
        endfunction

        function void note_request(input op_t op, input logic signed [31:0] v [3],
                                   input logic [30:0] m, input bit by_speed, input bit no_mass);
            logic signed [95:0] f;
            logic [31:0] dt;
            logic signed [31:0] p [3];
            motion_t res;
            case (op)
                OP_BEGIN:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        vel[i] = v[i];
                        accel[i] = 0;
                    end
                    mass = {1'b0, m};
                    speed_valid = 0;
                end
                OP_FORCE:
                begin
                    if (by_speed && !speed_valid)
                    begin
                        speed = root_of_squares();
                        speed_valid = 1;
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        f = 96'(v[i]);
                        if (by_speed)
                            f = 96'(scale(v[i], speed));
                        if (!no_mass && mass != 0)
                            f = 96'(clamp((f * 65536) / $signed({64'd0, mass})));
                        accel[i] = clamp(96'(accel[i]) + f);
                    end
                end
                OP_INTEG:
                begin
                    dt = {1'b0, step_size} / STEPS;
                    for (int i = 0; i < 3; i++)
                        p[i] = v[i];
                    for (int s = 0; s < STEPS; s++)
                        for (int i = 0; i < 3; i++)
                        begin
                            vel[i] = clamp(96'(vel[i]) + 96'(scale(accel[i], dt)));
                            p[i] = clamp(96'(p[i]) + 96'(scale(vel[i], dt)));
                        end
                    speed_valid = 0;
                    res = {p[2], p[1], p[0], vel[2], vel[1], vel[0]};
                    awaited.push_back(res);
                end
                default:
                begin
                    // unused op leaves everything alone
                end
            endcase
        endfunction

        function void check_result(input motion_t got);
            motion_t exp;
            results_seen++;
            if (awaited.size() == 0)
            begin
                $error("unexpected motion result %h", got);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.vx !== exp.vx) begin $error("new_vel_x exp %h got %h", exp.vx, got.vx); errors++; end
            if (got.vy !== exp.vy) begin $error("new_vel_y exp %h got %h", exp.vy, got.vy); errors++; end
            if (got.vz !== exp.vz) begin $error("new_vel_z exp %h got %h", exp.vz, got.vz); errors++; end
            if (got.px !== exp.px) begin $error("new_pos_x exp %h got %h", exp.px, got.px); errors++; end
            if (got.py !== exp.py) begin $error("new_pos_y exp %h got %h", exp.py, got.py); errors++; end
            if (got.pz !== exp.pz) begin $error("new_pos_z exp %h got %h", exp.pz, got.pz); errors++; end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = 2'd0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [191:0] m_axis_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [30:0] cfg_data = '0;

    motion_scoreboard board;
    bit calm_phase = 0;       // no idling near the end
    bit hold_sink = 0;        // receiver holds off a long stretch
    int quiet_cycles = 0;
    int requests_sent = 0;

    always #1 clk = ~clk;

    euler_force_integrator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // receiver: random stall bursts, or a long hold when asked
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 0;
                repeat (400) @(posedge clk);
                hold_sink = 0;
            end
            else if (!calm_phase && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 13);
                m_axis_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1;
                @(posedge clk);
            end
        end
    end

    // check every accepted result
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);

    // watchdog on cycles with no accepted request, result or time step write
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // valid stays up after acceptance until an idle gap or a pause drops it
    task automatic send_request(input op_t op, input logic signed [31:0] x,
                                input logic signed [31:0] y, input logic signed [31:0] z,
                                input logic [30:0] m, input bit by_speed, input bit no_mass);
        logic signed [31:0] v [3];
        if (!calm_phase && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        v[0] = x;
        v[1] = y;
        v[2] = z;
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'b0, no_mass, by_speed, m, z, y, x};
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(op, v, m, by_speed, no_mass);
        requests_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        // a force request may still be in work with nothing awaited
        repeat (400) @(posedge clk);
    endtask

    task automatic write_step(input logic [30:0] value);
        cfg_valid <= 1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        board.step_size = value;
        cfg_valid <= 0;
    endtask

    function automatic logic signed [31:0] pick_value(input int span);
        logic signed [31:0] r;
        case ($urandom_range(0, 5))
            0: r = 32'sh7fffffff;
            1: r = 32'sh80000000;
            2: r = $urandom;
            default: r = $signed($urandom_range(0, span)) - span / 2;
        endcase
        return r;
    endfunction

    // one entity: begin, up to four forces, one or two integrates
    task automatic random_entity(input int span);
        int forces;
        send_request(OP_BEGIN, pick_value(span), pick_value(span), pick_value(span),
                     ($urandom_range(0, 7) == 0) ? 31'd0 :
                     ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 20)),
                     0, 0);
        forces = $urandom_range(0, 4);
        for (int i = 0; i < forces; i++)
            send_request(OP_FORCE, pick_value(span), pick_value(span), pick_value(span),
                         31'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        send_request(OP_INTEG, pick_value(span), pick_value(span), pick_value(span),
                     31'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 4) == 0)
            send_request(OP_INTEG, pick_value(span), pick_value(span), pick_value(span),
                         31'($urandom), 0, 0);
    endtask

    initial
    begin
        logic [30:0] steps [4];
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: force before begin, extremes, zero mass, unused op
        send_request(OP_FORCE, 32'sh00010000, -32'sh00020000, 0, 0, 1, 0);
        send_request(OP_INTEG, 0, 0, 0, 0, 0, 0);
        send_request(OP_BEGIN, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 0, 0);
        send_request(OP_FORCE, 32'sh7fffffff, 32'sh80000000, 32'sh00010000, 0, 1, 0);
        send_request(OP_FORCE, 32'sh80000000, 32'sh7fffffff, -1, 0, 0, 1);
        send_request(OP_NONE, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 1, 1);
        send_request(OP_INTEG, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0);
        send_request(OP_INTEG, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0);
        // speed after integrate measures the new velocity
        send_request(OP_FORCE, 32'sh00030000, 32'sh00040000, 0, 0, 1, 1);
        send_request(OP_INTEG, 0, 0, 0, 0, 0, 0);
        send_request(OP_BEGIN, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0);
        send_request(OP_FORCE, 32'sh00010000, 32'sh00010000, 32'sh00010000, 0, 1, 0);
        send_request(OP_FORCE, -32'sh00010000, 0, 32'sh00008000, 0, 0, 0);
        send_request(OP_INTEG, 32'sh00100000, -32'sh00100000, 0, 0, 0, 0);
        send_request(OP_BEGIN, -32'sh00020000, 1, -1, 31'd1, 0, 0);
        send_request(OP_FORCE, 32'sh7fffffff, 32'sh80000000, 32'sh12345678, 0, 0, 0);
        send_request(OP_INTEG, 0, 0, 0, 0, 0, 0);

        // sender pause until all results are back
        drain_results();

        // long receiver hold while requests keep coming
        hold_sink = 1;
        for (int i = 0; i < 4; i++)
            random_entity(1 << 22);

        steps[0] = 31'd0;
        steps[1] = 31'h7fffffff;
        steps[2] = 31'd65536;
        steps[3] = TIME_STEP_RST;
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            write_step(steps[ph] == 31'd65536 ? 31'($urandom) : steps[ph]);
            if (ph == 3)
                calm_phase = 1;
            while (requests_sent < 25 + (ph + 1) * (ITEM_COUNT / 4))
                random_entity((ph % 2) ? 32'h7fffffff : (1 << 20));
        end

        s_axis_tvalid <= 0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d requests and %0d motion results over four time steps",
                 requests_sent, board.results_seen);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
